// ===== rtl/core/positional_list_engine_core_assert.svh =====
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/plist_pkg.sv =====
// Types and constants of the positional list engine.
`timescale 1ns / 1ps
package plist_pkg;

  localparam int PosWidth     = 6;
  localparam int ValueWidth   = 32;
  localparam int CountOutW    = 6;
  localparam int MaxResults   = 32;
  localparam int MaxDataWidth = 64;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_READ      = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_TRAVERSE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_TRAV   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_GRAB,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_TRAV_RD,
    S_TRAV_OUT,
    S_RESULT
  } state_e;

endpackage

// ===== rtl/core/positional_list_engine_core.sv =====
// Positional list engine: bounded ordered list with insert/delete/read/overwrite/clear/traverse.
`timescale 1ns / 1ps
`include "positional_list_engine_core_assert.svh"
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries op_i, position_i, value_i.
//    One command is taken at a time; in_ready_o is high only while idle, so the
//    next command can transfer the cycle after the final result is loaded.
//  - Output channel (out_valid_o/out_ready_i) carries one result per transfer:
//    data_out_o, count_o, full_res_o, empty_res_o, status_o, last_o.
//    last_o marks the final result of a command.
//  - Entries live in a CAPACITY x DATA_WIDTH single-port-write, one-read memory
//    with a registered read. One sequencer drives that memory port.
//  - Sequencing: overwrite, clear and rejected commands go from the execute state
//    straight to the result; read and delete grab the entry first. Insert at position
//    p with n entries moves entries p..n-1 up one place; delete moves those above p down.
//    Traverse reads and emits the entries in order (min(n, 32) entries).
//    Each entry move is a read state followed by a write state.
//  - A stalled receiver holds the result in the output register; the sequencer
//    waits in its emit state until the register frees up.
//  - Reset empties the list (count goes to 0) and clears the output valid flag.
//    Memory contents are not cleared; only entries below the count are read.
module positional_list_engine_core #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          op_i,
  input  logic [plist_pkg::PosWidth-1:0]      position_i,
  input  logic [plist_pkg::ValueWidth-1:0]    value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [plist_pkg::ValueWidth-1:0]    data_out_o,
  output logic [plist_pkg::CountOutW-1:0]     count_o,
  output logic                                full_res_o,
  output logic                                empty_res_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int CmpW = (CntW > plist_pkg::PosWidth) ? CntW : plist_pkg::PosWidth;

  // sequencer and command registers
  plist_pkg::state_e  state_q, state_d;
  plist_pkg::op_e     op_q;
  logic [plist_pkg::PosWidth-1:0] pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  plist_pkg::status_e status_q, status_d;

  // entry store
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  wr_en, rd_en;
  logic [CntW-1:0]       wr_idx, rd_idx;
  logic [DATA_WIDTH-1:0] wr_data;

  // output register
  logic out_valid_q, out_valid_d;
  logic [plist_pkg::ValueWidth-1:0] out_data_q;
  logic [plist_pkg::CountOutW-1:0]  out_count_q;
  logic out_full_q, out_empty_q, out_last_q;
  plist_pkg::status_e out_status_q;
  logic emit;
  logic [DATA_WIDTH-1:0] emit_data;
  plist_pkg::status_e emit_status;
  logic emit_last;

  logic [plist_pkg::MaxDataWidth-1:0] value_ext, emit_ext;
  logic in_fire, out_free;
  logic [CmpW-1:0] pos_x, cnt_x, idx_x, trav_n;
  logic ins_full, ins_bad, pos_bad, ins_step_end, del_step_end, grab_end, trav_last;
  logic is_ins;

  assign in_ready_o = (state_q == plist_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign value_ext  = plist_pkg::MaxDataWidth'(value_i);

  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(count_q);
  assign idx_x  = CmpW'(idx_q);
  assign trav_n = (cnt_x > CmpW'(plist_pkg::MaxResults)) ?
                  CmpW'(plist_pkg::MaxResults) : cnt_x;

  assign ins_full     = cnt_x >= CmpW'(CAPACITY);
  assign ins_bad      = pos_x > cnt_x;
  assign pos_bad      = pos_x >= cnt_x;
  assign ins_step_end = idx_x == pos_x + CmpW'(1);
  assign del_step_end = idx_x + CmpW'(1) == cnt_x;
  assign grab_end     = pos_x + CmpW'(1) == cnt_x;
  assign trav_last    = idx_x + CmpW'(1) == trav_n;
  assign is_ins       = (op_q == plist_pkg::OP_INSERT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plist_pkg::S_IDLE: begin
        if (in_fire) state_d = plist_pkg::S_EXEC;
      end
      plist_pkg::S_EXEC: begin
        state_d = plist_pkg::S_RESULT;
        unique case (op_q) inside
          plist_pkg::OP_INSERT: begin
            if (!ins_full && !ins_bad) begin
              state_d = (cnt_x == pos_x) ? plist_pkg::S_PLACE : plist_pkg::S_SHIFT_RD;
            end
          end
          plist_pkg::OP_DELETE, plist_pkg::OP_READ: begin
            if (!pos_bad) state_d = plist_pkg::S_GRAB;
          end
          plist_pkg::OP_TRAVERSE: begin
            if (count_q != '0) state_d = plist_pkg::S_TRAV_RD;
          end
          default: ;
        endcase
      end
      plist_pkg::S_GRAB: begin
        if (op_q == plist_pkg::OP_DELETE && !grab_end) state_d = plist_pkg::S_SHIFT_RD;
        else state_d = plist_pkg::S_RESULT;
      end
      plist_pkg::S_SHIFT_RD: state_d = plist_pkg::S_SHIFT_WR;
      plist_pkg::S_SHIFT_WR: begin
        if (is_ins) state_d = ins_step_end ? plist_pkg::S_PLACE : plist_pkg::S_SHIFT_RD;
        else state_d = del_step_end ? plist_pkg::S_RESULT : plist_pkg::S_SHIFT_RD;
      end
      plist_pkg::S_PLACE: state_d = plist_pkg::S_RESULT;
      plist_pkg::S_TRAV_RD: state_d = plist_pkg::S_TRAV_OUT;
      plist_pkg::S_TRAV_OUT: begin
        if (out_free) state_d = trav_last ? plist_pkg::S_IDLE : plist_pkg::S_TRAV_RD;
      end
      plist_pkg::S_RESULT: begin
        if (out_free) state_d = plist_pkg::S_IDLE;
      end
      default: state_d = plist_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    data_d      = data_q;
    status_d    = status_q;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_data     = rd_data_q;
    rd_en       = 1'b0;
    rd_idx      = idx_q;
    emit        = 1'b0;
    emit_data   = data_q;
    emit_status = status_q;
    emit_last   = 1'b1;
    unique case (state_q)
      plist_pkg::S_EXEC: begin
        data_d   = '0;
        status_d = plist_pkg::ST_OK;
        unique case (op_q) inside
          plist_pkg::OP_INSERT: begin
            if (ins_full) status_d = plist_pkg::ST_FULL;
            else if (ins_bad) status_d = plist_pkg::ST_BAD_POS;
            else idx_d = count_q;
          end
          plist_pkg::OP_DELETE, plist_pkg::OP_READ: begin
            if (pos_bad) begin
              status_d = plist_pkg::ST_BAD_POS;
            end else begin
              rd_en  = 1'b1;
              rd_idx = CntW'(pos_q);
            end
          end
          plist_pkg::OP_OVERWRITE: begin
            if (pos_bad) begin
              status_d = plist_pkg::ST_BAD_POS;
            end else begin
              wr_en   = 1'b1;
              wr_idx  = CntW'(pos_q);
              wr_data = val_q;
            end
          end
          plist_pkg::OP_CLEAR: count_d = '0;
          plist_pkg::OP_TRAVERSE: begin
            if (count_q == '0) status_d = plist_pkg::ST_NO_TRAV;
            else idx_d = '0;
          end
          default: ;
        endcase
      end
      plist_pkg::S_GRAB: begin
        data_d = rd_data_q;
        if (op_q == plist_pkg::OP_DELETE) begin
          if (grab_end) count_d = count_q - CntW'(1);
          else idx_d = CntW'(pos_q) + CntW'(1);
        end
      end
      plist_pkg::S_SHIFT_RD: begin
        rd_en  = 1'b1;
        rd_idx = is_ins ? idx_q - CntW'(1) : idx_q;
      end
      plist_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_idx  = is_ins ? idx_q : idx_q - CntW'(1);
        wr_data = rd_data_q;
        if (is_ins) begin
          idx_d = idx_q - CntW'(1);
        end else begin
          idx_d = idx_q + CntW'(1);
          if (del_step_end) count_d = count_q - CntW'(1);
        end
      end
      plist_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_idx  = CntW'(pos_q);
        wr_data = val_q;
        count_d = count_q + CntW'(1);
      end
      plist_pkg::S_TRAV_RD: begin
        rd_en = 1'b1;
      end
      plist_pkg::S_TRAV_OUT: begin
        emit_data   = rd_data_q;
        emit_status = plist_pkg::ST_OK;
        emit_last   = trav_last;
        if (out_free) begin
          emit  = 1'b1;
          idx_d = idx_q + CntW'(1);
        end
      end
      plist_pkg::S_RESULT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  assign emit_ext    = plist_pkg::MaxDataWidth'(emit_data);
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plist_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= plist_pkg::op_e'(op_i);
      pos_q <= position_i;
      val_q <= value_ext[DATA_WIDTH-1:0];
    end
    idx_q    <= idx_d;
    data_q   <= data_d;
    status_q <= status_d;
    if (emit) begin
      out_data_q   <= emit_ext[plist_pkg::ValueWidth-1:0];
      out_count_q  <= plist_pkg::CountOutW'(count_q);
      out_full_q   <= (count_q == CntW'(CAPACITY));
      out_empty_q  <= (count_q == '0);
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  // entry store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx[AddrW-1:0]] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_idx[AddrW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign count_o     = out_count_q;
  assign full_res_o  = out_full_q;
  assign empty_res_o = out_empty_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `PLE_ASSERT_NOW(a_wr_in_range, wr_en, wr_idx < CntW'(CAPACITY), "write beyond store")
  `PLE_ASSERT_NOW(a_rd_in_range, rd_en, rd_idx < CntW'(CAPACITY), "read beyond store")
  `PLE_ASSERT_NOW(a_emit_slot, emit, !out_valid_q || out_ready_i, "result overwritten")
  `PLE_ASSERT_NEXT(a_count_step, 1'b1,
                   count_q == $past(count_q) || count_q == '0 ||
                   count_q == $past(count_q) + CntW'(1) ||
                   count_q == $past(count_q) - CntW'(1), "count jumped")

endmodule

// ===== bench/positional_list_engine_core_check.sv =====
// Checker for the positional list engine: tracks list contents and compares every result.
`timescale 1ns / 1ps
module positional_list_engine_core_check #(
  parameter int Capacity = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [2:0]                       op_i,
  input  logic [plist_pkg::PosWidth-1:0]   position_i,
  input  logic [plist_pkg::ValueWidth-1:0] value_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [plist_pkg::ValueWidth-1:0] data_out_i,
  input  logic [plist_pkg::CountOutW-1:0]  count_i,
  input  logic                             full_res_i,
  input  logic                             empty_res_i,
  input  logic [1:0]                       status_i,
  input  logic                             last_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);

  typedef struct packed {
    logic [plist_pkg::ValueWidth-1:0] data;
    logic [plist_pkg::CountOutW-1:0]  count;
    logic                             full;
    logic                             empty;
    plist_pkg::status_e               status;
    logic                             last;
  } list_reply_t;

  logic [plist_pkg::ValueWidth-1:0] list_store [Capacity];
  int unsigned                      list_len;
  list_reply_t                      list_replies [$];
  int unsigned                      mismatches;
  int unsigned                      results_seen;

  function automatic list_reply_t make_reply(logic [plist_pkg::ValueWidth-1:0] data,
                                             plist_pkg::status_e st, logic fin);
    list_reply_t r;
    r.data   = data;
    r.count  = plist_pkg::CountOutW'(list_len);
    r.full   = (list_len == Capacity);
    r.empty  = (list_len == 0);
    r.status = st;
    r.last   = fin;
    return r;
  endfunction

  // Apply one command to the shadow list and queue the replies it produces.
  task automatic step_list(logic [2:0] op, logic [plist_pkg::PosWidth-1:0] pos,
                           logic [plist_pkg::ValueWidth-1:0] val);
    logic [plist_pkg::ValueWidth-1:0] data;
    plist_pkg::status_e               st;
    int unsigned                      n;
    int unsigned                      i;
    data = '0;
    st   = plist_pkg::ST_OK;
    case (op)
      plist_pkg::OP_INSERT: begin
        // full check wins over the position check
        if (list_len >= Capacity) begin
          st = plist_pkg::ST_FULL;
        end else if (pos > list_len) begin
          st = plist_pkg::ST_BAD_POS;
        end else begin
          for (i = list_len; i > pos; i--) list_store[i] = list_store[i-1];
          list_store[pos] = val;
          list_len++;
        end
      end
      plist_pkg::OP_DELETE: begin
        if (pos >= list_len) begin
          st = plist_pkg::ST_BAD_POS;
        end else begin
          data = list_store[pos];
          for (i = pos + 1; i < list_len; i++) list_store[i-1] = list_store[i];
          list_len--;
        end
      end
      plist_pkg::OP_READ: begin
        if (pos >= list_len) st = plist_pkg::ST_BAD_POS;
        else data = list_store[pos];
      end
      plist_pkg::OP_OVERWRITE: begin
        if (pos >= list_len) st = plist_pkg::ST_BAD_POS;
        else list_store[pos] = val;
      end
      plist_pkg::OP_CLEAR: list_len = 0;
      plist_pkg::OP_TRAVERSE: begin
        if (list_len == 0) begin
          st = plist_pkg::ST_NO_TRAV;
        end else begin
          n = (list_len > plist_pkg::MaxResults) ? plist_pkg::MaxResults : list_len;
          for (i = 0; i < n; i++) begin
            list_replies.push_back(make_reply(list_store[i], plist_pkg::ST_OK, i + 1 == n));
          end
          return;
        end
      end
      default: ;  // spare codes: one plain reply, no state change
    endcase
    list_replies.push_back(make_reply(data, st, 1'b1));
  endtask

  function automatic int field_diff(string name, logic [plist_pkg::ValueWidth-1:0] want,
                                    logic [plist_pkg::ValueWidth-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      list_len     = 0;
      mismatches   = 0;
      results_seen = 0;
      list_replies.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (list_replies.size() == 0) begin
          $error("result with nothing pending: data_out %0h status %0d", data_out_i, status_i);
          mismatches++;
        end else begin
          want = list_replies.pop_front();
          mismatches += field_diff("data_out", want.data, data_out_i);
          mismatches += field_diff("count", want.count, count_i);
          mismatches += field_diff("full_res", want.full, full_res_i);
          mismatches += field_diff("empty_res", want.empty, empty_res_i);
          mismatches += field_diff("status", want.status, status_i);
          mismatches += field_diff("last", want.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) step_list(op_i, position_i, value_i);
      fail_count_o <= mismatches;
      pending_o    <= list_replies.size();
      checked_o    <= results_seen;
    end
  end

endmodule

// ===== bench/positional_list_engine_core_test.sv =====
// Testbench top for the positional list engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module positional_list_engine_core_test;

  localparam int          Capacity     = 32;
  localparam int unsigned RandomItems  = 480;
  // worst insert moves CAPACITY-1 entries; leave margin after the last result
  localparam int unsigned SettleCycles = 2 * Capacity + 16;
  // watchdog limit, well above the slowest legal run
  localparam int unsigned CycleLimit   = 1_000_000;

  // op codes the block does not define; it must answer them with a plain ok
  localparam logic [2:0]  OpSpareLo    = 3'd6;
  localparam logic [2:0]  OpSpareHi    = 3'd7;

  logic                             clk_i      = 1'b0;
  logic                             rst_ni     = 1'b0;
  logic                             in_valid   = 1'b0;
  logic [2:0]                       op         = '0;
  logic [plist_pkg::PosWidth-1:0]   position   = '0;
  logic [plist_pkg::ValueWidth-1:0] value      = '0;
  logic                             out_ready  = 1'b0;

  logic                             in_ready;
  logic                             out_valid;
  logic [plist_pkg::ValueWidth-1:0] data_out;
  logic [plist_pkg::CountOutW-1:0]  count;
  logic                             full_res;
  logic                             empty_res;
  logic [1:0]                       status;
  logic                             last;

  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           checked;

  // Stimulus-side bookkeeping: list length as the stimulus sees it, so that
  // positions can be aimed inside or just outside the occupied range.
  int unsigned           fill        = 0;
  int unsigned           sent        = 0;
  int unsigned           burst_left  = 0;
  int unsigned           full_hits   = 0;
  int unsigned           op_tally [8];
  int unsigned           cycle_count = 0;

  // Receiver pacing state
  logic [6:0]            rx_left     = '0;
  logic [1:0]            rx_mode     = '0;

  always #1 clk_i = ~clk_i;

  positional_list_engine_core #(
    .CAPACITY   (Capacity),
    .DATA_WIDTH (plist_pkg::ValueWidth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .position_i  (position),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_out_o  (data_out),
    .count_o     (count),
    .full_res_o  (full_res),
    .empty_res_o (empty_res),
    .status_o    (status),
    .last_o      (last)
  );

  positional_list_engine_core_check #(
    .Capacity (Capacity)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .position_i   (position),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .data_out_i   (data_out),
    .count_i      (count),
    .full_res_i   (full_res),
    .empty_res_i  (empty_res),
    .status_i     (status),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver: picks a stall mode for a random stretch of cycles.
  //   mode 0: always ready (no backpressure at all)
  //   mode 1: mostly ready
  //   mode 2: coin flip
  //   mode 3: ready one cycle in eight (long stalls on the output register)
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= 7'($urandom_range(8, 100));
    end else begin
      rx_left <= rx_left - 7'd1;
    end
    case (rx_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_left[2:0] == 3'd0);
    endcase
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("no progress after %0d cycles, %0d results still pending", CycleLimit, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [plist_pkg::ValueWidth-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Insert position: mostly legal (0..fill), with the ends and some
  // out-of-range positions mixed in.
  function automatic logic [plist_pkg::PosWidth-1:0] insert_pos();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0 && fill < 63) return plist_pkg::PosWidth'($urandom_range(fill + 1, 63));
    if (r == 1) return plist_pkg::PosWidth'(fill);
    if (r == 2) return '0;
    return plist_pkg::PosWidth'($urandom_range(0, fill));
  endfunction

  // Position of an existing entry, or past the end now and then.
  function automatic logic [plist_pkg::PosWidth-1:0] entry_pos();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (fill == 0 || r == 0) return plist_pkg::PosWidth'($urandom_range(fill, 63));
    if (r == 1) return plist_pkg::PosWidth'(fill - 1);
    if (r == 2) return '0;
    return plist_pkg::PosWidth'($urandom_range(0, fill - 1));
  endfunction

  // Random position anywhere in the 6-bit range.
  function automatic logic [plist_pkg::PosWidth-1:0] any_pos();
    return plist_pkg::PosWidth'($urandom_range(0, 63));
  endfunction

  // Sender pacing: bursts of back-to-back transfers with random gaps between.
  // Valid drops only between transfers (here or in drain_wait), so it never falls mid-item.
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Present one command and hold it until the transfer happens.
  task automatic send(logic [2:0] code, logic [plist_pkg::PosWidth-1:0] pos,
                      logic [plist_pkg::ValueWidth-1:0] val);
    in_valid <= 1'b1;
    op       <= code;
    position <= pos;
    value    <= val;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    op_tally[code]++;
    // track the length the block should now hold
    case (code)
      plist_pkg::OP_INSERT: if (fill < Capacity && pos <= fill) begin
        fill++;
        if (fill == Capacity) full_hits++;
      end
      plist_pkg::OP_DELETE: if (pos < fill) fill--;
      plist_pkg::OP_CLEAR:  fill = 0;
      default: ;
    endcase
    pace();
  endtask

  // Hold off the sender until every outstanding result has been seen.
  // The checker registers the last transfer before pending is first checked.
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Fill to capacity with legal inserts, poke the full list, then walk it.
  task automatic fill_run();
    while (fill < Capacity) begin
      if ($urandom_range(0, 9) == 0) begin
        send(plist_pkg::OP_OVERWRITE, entry_pos(), rand_value());
      end else begin
        send(plist_pkg::OP_INSERT, plist_pkg::PosWidth'($urandom_range(0, fill)),
             rand_value());
      end
    end
    repeat ($urandom_range(1, 2)) send(plist_pkg::OP_INSERT, any_pos(), rand_value());
    send(plist_pkg::OP_READ, entry_pos(), rand_value());
    send(plist_pkg::OP_TRAVERSE, any_pos(), rand_value());
  endtask

  // Delete down to empty, then hit the empty-list cases.
  task automatic drain_run();
    while (fill > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        send(plist_pkg::OP_READ, entry_pos(), rand_value());
      end else begin
        send(plist_pkg::OP_DELETE, plist_pkg::PosWidth'($urandom_range(0, fill - 1)),
             rand_value());
      end
    end
    send(plist_pkg::OP_DELETE, any_pos(), rand_value());
    send(plist_pkg::OP_TRAVERSE, any_pos(), rand_value());
  endtask

  // Weighted mix of all operations, plus unconstrained noise.
  task automatic mixed_run();
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    n = $urandom_range(8, 30);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      send(plist_pkg::OP_INSERT, insert_pos(), rand_value());
      else if (pick < 50) send(plist_pkg::OP_DELETE, entry_pos(), rand_value());
      else if (pick < 64) send(plist_pkg::OP_READ, entry_pos(), rand_value());
      else if (pick < 78) send(plist_pkg::OP_OVERWRITE, entry_pos(), rand_value());
      else if (pick < 86) send(plist_pkg::OP_TRAVERSE, any_pos(), rand_value());
      else if (pick < 89) send(plist_pkg::OP_CLEAR, any_pos(), rand_value());
      else send(3'($urandom_range(0, 7)), any_pos(), $urandom);
    end
  endtask

  initial begin
    int unsigned random_base;
    int unsigned pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // empty list: every access is out of range, traverse has nothing to emit
    send(plist_pkg::OP_TRAVERSE,  6'd0,  '0);
    send(plist_pkg::OP_DELETE,    6'd0,  '0);
    send(plist_pkg::OP_READ,      6'd0,  '0);
    send(plist_pkg::OP_OVERWRITE, 6'd0,  '1);
    send(plist_pkg::OP_INSERT,    6'd1,  '1);
    // inserts at the head shift existing entries up without wrapping
    send(plist_pkg::OP_INSERT,    6'd0,  '0);
    send(plist_pkg::OP_INSERT,    6'd0,  '1);
    send(plist_pkg::OP_INSERT,    6'd2,  32'hA5A5_A5A5);
    send(plist_pkg::OP_INSERT,    6'd1,  32'h5A5A_5A5A);
    send(plist_pkg::OP_READ,      6'd0,  '0);
    send(plist_pkg::OP_READ,      6'd3,  '0);
    send(plist_pkg::OP_READ,      6'd4,  '0);
    send(plist_pkg::OP_READ,      6'd63, '1);
    send(plist_pkg::OP_OVERWRITE, 6'd3,  32'h8000_0001);
    send(plist_pkg::OP_OVERWRITE, 6'd63, '1);
    send(plist_pkg::OP_TRAVERSE,  6'd63, '1);
    // delete at the head, at the tail and past the end
    send(plist_pkg::OP_DELETE,    6'd0,  '0);
    send(plist_pkg::OP_DELETE,    6'd2,  '0);
    send(plist_pkg::OP_DELETE,    6'd63, '1);
    // spare op codes pass through without touching the list
    send(OpSpareLo,               6'd0,  '1);
    send(OpSpareHi,               6'd63, '1);
    send(plist_pkg::OP_CLEAR,     6'd63, '1);
    send(plist_pkg::OP_TRAVERSE,  6'd0,  '0);
    send(plist_pkg::OP_READ,      6'd0,  '0);

    // let the output side run dry once before the random part
    drain_wait();

    // ---- random part ----
    random_base = sent;
    while (sent - random_base < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      fill_run();
      else if (pick < 45) drain_run();
      else if (pick < 90) mixed_run();
      else drain_wait();
    end

    drain_wait();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d transfers: %0d insert, %0d delete, %0d read, %0d overwrite,",
             sent, op_tally[plist_pkg::OP_INSERT], op_tally[plist_pkg::OP_DELETE],
             op_tally[plist_pkg::OP_READ], op_tally[plist_pkg::OP_OVERWRITE]);
    $display("  %0d clear, %0d traverse, %0d spare op; %0d results checked, %0d times full",
             op_tally[plist_pkg::OP_CLEAR], op_tally[plist_pkg::OP_TRAVERSE],
             op_tally[OpSpareLo] + op_tally[OpSpareHi], checked, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/plist_pkg.sv
rtl/core/positional_list_engine_core.sv
bench/positional_list_engine_core_check.sv
bench/positional_list_engine_core_test.sv
